@@ hdl/fixed_block_pool_allocator_macros.svh @@
// Assertion macros for the fixed block pool allocator.
// Included by the top level; no other dependencies.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define FBPA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FBPA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/fbpa_pkg.sv @@
// Shared types, codes and helpers for the fixed block pool allocator.
// No dependencies; imported by every module of the block.
package fbpa_pkg;

   localparam int ADDR_W      = 32;
   localparam int SIZE_CFG_W  = 16;
   localparam int SIZE_W      = 17;
   localparam int NUM_CFG_W   = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int STATUS_W    = 2;
   localparam int IDX_OUT_W   = 6;
   localparam int LEFT_W      = 7;
   localparam int ROW_BITS    = 8;
   localparam int BIT_POS_W   = 3;

   localparam logic [ROW_BITS-1:0] FILL_BYTE = 8'hFF;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PTR     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE_FREE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLK_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLK_COUNT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_LOOKUP,
      ST_FINISH
   } fbpa_state_type;

   typedef struct packed {
      logic              op;
      logic [ADDR_W-1:0] address;
   } fbpa_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ADDR_W-1:0]    block_address;
      logic [IDX_OUT_W-1:0] block_index;
      logic [LEFT_W-1:0]    blocks_left;
   } fbpa_rsp_type;

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] dividend;
      logic [SIZE_W-1:0] divisor;
   } fbpa_div_req_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] quotient;
      logic              rem_zero;
   } fbpa_div_rsp_type;

   // round up to a multiple of four, zero becomes four
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_CFG_W-1:0] v);
      logic [SIZE_W-1:0] s;
      s = ({1'b0, v} + SIZE_W'(3)) & ~SIZE_W'(3);
      if (s == '0) begin
         s = SIZE_W'(4);
      end
      return s;
   endfunction

endpackage

@@ hdl/fbpa_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on fbpa_pkg.
module fbpa_div import fbpa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  fbpa_div_req_type div_req,
   output fbpa_div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(ADDR_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] quo_ff, quo_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] dvs_ff, dvs_in;

   logic [SIZE_W:0] trial;
   logic [SIZE_W:0] diff;
   logic            fits;

   always_comb begin
      trial = {rem_ff, quo_ff[ADDR_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ADDR_W);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? SIZE_W'(diff) : SIZE_W'(trial);
         quo_in = {quo_ff[ADDR_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign div_rsp.rem_zero = (rem_ff == '0);

endmodule

@@ hdl/fbpa_map.sv @@
// Free-mark bitmap: byte rows in a memory with one valid bit per row.
// A row never written since the last clear reads as all free. Depends on fbpa_pkg.
module fbpa_map import fbpa_pkg::*; #(
   parameter  int MAX_BLOCKS = 64,
   localparam int ROWS = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS,
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic [RW-1:0]       rd_row,
   output logic [ROW_BITS-1:0] rd_data,
   input  logic                wr_en,
   input  logic [RW-1:0]       wr_row,
   input  logic [ROW_BITS-1:0] wr_data
);

   logic [ROW_BITS-1:0] mem_ff [ROWS];
   logic [ROWS-1:0]     row_valid_ff;
   logic [ROW_BITS-1:0] rd_raw_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row] <= wr_data;
      end
      rd_raw_ff <= mem_ff[rd_row];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (clear) begin
            row_valid_ff <= '0;
         end else if (wr_en) begin
            row_valid_ff[wr_row] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_row];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : FILL_BYTE;

endmodule

@@ hdl/fixed_block_pool_allocator.sv @@
// Fixed block pool allocator, top level; uses fbpa_pkg, fbpa_div, fbpa_map and the
// assertion macro header. One request at a time, one response per request. An
// allocate scans the free bitmap one row of eight marks per cycle, scanning 1 to
// ceil(blocks in use/8) rows; with no free block it skips the scan. A free runs
// the offset through a 32-step serial divider, one quotient bit per cycle, and
// skips the bitmap lookup when the pointer is rejected. Writing the block size or
// block count register marks every block free at once through per-row valid
// bits; no clearing pass. Configuration writes are taken only while no request
// is in flight.
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator import fbpa_pkg::*; #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fbpa_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fbpa_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW   = $clog2(MAX_BLOCKS + 1);
   localparam int IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int ROWS = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PW   = IW + SIZE_W;

   function automatic logic [CW-1:0] clamp_count(input logic [NUM_CFG_W-1:0] v);
      logic [CW-1:0] r;
      if (v == '0) begin
         r = CW'(1);
      end else if (int'(v) > MAX_BLOCKS) begin
         r = CW'(MAX_BLOCKS);
      end else begin
         r = CW'(v);
      end
      return r;
   endfunction

   fbpa_state_type state_ff, state_in;

   logic                op_ff, op_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ROW_BITS-1:0] wr_data_ff, wr_data_in;
   logic [ADDR_W-1:0]   prod_ff, prod_in;
   logic [CW-1:0]       free_count_ff, free_count_in;
   logic [ADDR_W-1:0]   pool_base_ff, pool_base_in;
   logic [SIZE_W-1:0]   bs_eff_ff, bs_eff_in;
   logic [CW-1:0]       n_eff_ff, n_eff_in;
   logic                rsp_valid_ff, rsp_valid_in;
   fbpa_rsp_type        rsp_data_ff, rsp_data_in;

   logic accept;
   logic csr_write;
   logic out_free;

   fbpa_div_req_type    div_req;
   fbpa_div_rsp_type    div_rsp;
   logic                map_clear;
   logic [RW-1:0]       map_rd_row;
   logic [ROW_BITS-1:0] map_rd_data;
   logic                map_wr_en;
   logic [RW-1:0]       map_wr_row;
   logic [ROW_BITS-1:0] map_wr_data;

   logic [RW+2:0]        row_base;
   logic [ROW_BITS-1:0]  in_range;
   logic [ROW_BITS-1:0]  masked;
   logic [BIT_POS_W-1:0] hit_pos;
   logic                 scan_hit;
   logic [ROW_BITS-1:0]  hit_mask;
   logic [ROW_BITS-1:0]  lookup_mask;
   logic                 free_bad;

   fbpa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   fbpa_map #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .clear   (map_clear),
      .rd_row  (map_rd_row),
      .rd_data (map_rd_data),
      .wr_en   (map_wr_en),
      .wr_row  (map_wr_row),
      .wr_data (map_wr_data)
   );

   assign accept    = req_valid && !req_stall;
   assign csr_write = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // row scan: lowest free mark among blocks in use
   always_comb begin
      row_base = {row_ff, BIT_POS_W'(0)};
      for (int b = 0; b < ROW_BITS; b++) begin
         in_range[b] = ({row_ff, BIT_POS_W'(b)} < n_eff_ff);
      end
      masked  = map_rd_data & in_range;
      hit_pos = '0;
      for (int b = ROW_BITS - 1; b >= 0; b--) begin
         if (masked[b]) begin
            hit_pos = BIT_POS_W'(b);
         end
      end
      scan_hit    = |masked;
      hit_mask    = ROW_BITS'(1) << hit_pos;
      lookup_mask = ROW_BITS'(1) << BIT_POS_W'(idx_ff);
      free_bad    = (addr_ff == '0) || !div_rsp.rem_zero ||
                    (div_rsp.quotient >= ADDR_W'(n_eff_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (op_ff == OP_FREE) begin
               state_in = ST_DIV;
            end else if (free_count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_FINISH;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = free_bad ? ST_FINISH : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_stall        = (state_ff != ST_IDLE) || csr_valid;
      csr_ready        = (state_ff == ST_IDLE);
      div_req.start    = (state_ff == ST_START) && (op_ff == OP_FREE);
      div_req.dividend = addr_ff - pool_base_ff;
      div_req.divisor  = bs_eff_ff;
      map_rd_row       = row_in;
      map_wr_en        = (state_ff == ST_FINISH) && out_free && (status_ff == STATUS_OK);
      map_wr_row       = row_ff;
      map_wr_data      = wr_data_ff;
      map_clear        = csr_write &&
                         ((csr_index == CSR_BLK_BYTES) || (csr_index == CSR_BLK_COUNT));
      rsp_valid        = rsp_valid_ff;
      rsp_data         = rsp_data_ff;
   end

   // datapath and configuration
   always_comb begin
      op_in         = op_ff;
      addr_in       = addr_ff;
      row_in        = row_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      wr_data_in    = wr_data_ff;
      prod_in       = prod_ff;
      free_count_in = free_count_ff;
      pool_base_in  = pool_base_ff;
      bs_eff_in     = bs_eff_ff;
      n_eff_in      = n_eff_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            row_in = '0;
            if (accept) begin
               op_in     = req_data.op;
               addr_in   = req_data.address;
               status_in = STATUS_OK;
               idx_in    = '0;
            end
         end
         ST_START: begin
            if ((op_ff == OP_ALLOC) && (free_count_ff == '0)) begin
               status_in = STATUS_NO_FREE;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               idx_in     = IW'({row_ff, hit_pos});
               wr_data_in = map_rd_data & ~hit_mask;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end
         ST_MUL: begin
            prod_in = ADDR_W'(PW'(idx_ff) * PW'(bs_eff_ff));
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (free_bad) begin
                  status_in = STATUS_BAD_PTR;
               end else begin
                  idx_in = IW'(div_rsp.quotient);
                  row_in = RW'(div_rsp.quotient >> BIT_POS_W);
               end
            end
         end
         ST_LOOKUP: begin
            if ((map_rd_data & lookup_mask) != '0) begin
               status_in = STATUS_DOUBLE_FREE;
            end else begin
               wr_data_in = map_rd_data | lookup_mask;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if (status_ff == STATUS_OK) begin
                  free_count_in = (op_ff == OP_ALLOC) ? free_count_ff - CW'(1)
                                                      : free_count_ff + CW'(1);
               end
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.block_address =
                  ((op_ff == OP_ALLOC) && (status_ff == STATUS_OK)) ?
                  pool_base_ff + prod_ff : '0;
               rsp_data_in.block_index   = IDX_OUT_W'(idx_ff);
               rsp_data_in.blocks_left   = LEFT_W'(free_count_in);
            end
         end
         default: begin
         end
      endcase

      if (csr_write) begin
         unique case (csr_index)
            CSR_POOL_BASE: begin
               pool_base_in = ADDR_W'(csr_wdata);
            end
            CSR_BLK_BYTES: begin
               bs_eff_in     = eff_size(csr_wdata[SIZE_CFG_W-1:0]);
               free_count_in = n_eff_ff;
            end
            CSR_BLK_COUNT: begin
               n_eff_in      = clamp_count(csr_wdata[NUM_CFG_W-1:0]);
               free_count_in = n_eff_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         free_count_ff <= clamp_count(NUM_CFG_W'(64));
         pool_base_ff  <= '0;
         bs_eff_ff     <= SIZE_W'(32);
         n_eff_ff      <= clamp_count(NUM_CFG_W'(64));
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_count_ff <= free_count_in;
         pool_base_ff  <= pool_base_in;
         bs_eff_ff     <= bs_eff_in;
         n_eff_ff      <= n_eff_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      row_ff      <= row_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      wr_data_ff  <= wr_data_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   `FBPA_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, free_count_ff <= n_eff_ff,
      "free count exceeds blocks in use")
   `FBPA_ASSERT_IMPLY(a_div_done_in_div, clock, reset, div_rsp.done, state_ff == ST_DIV,
      "divider finished outside divide state")
   `FBPA_ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == ST_SCAN, row_base < n_eff_ff,
      "scan ran past the blocks in use")
   `FBPA_ASSERT_NEXT(a_alloc_count, clock, reset,
      (state_ff == ST_FINISH) && out_free && (op_ff == OP_ALLOC) && (status_ff == STATUS_OK),
      free_count_ff == $past(free_count_ff) - CW'(1), "allocate did not take one free block")

endmodule
